@@ design/htm_pkg.sv @@
// Shared types, codes and helpers for the header token matcher.
package htm_pkg;

    localparam int TOKEN_COUNT_DEF   = 16;
    localparam int TOKEN_MAX_LEN_DEF = 64;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_MESSAGE = 1'b1;

    localparam logic [2:0] MODE_PREFIX_FOLD = 3'd0;
    localparam logic [2:0] MODE_PREFIX_CASE = 3'd1;
    localparam logic [2:0] MODE_WHOLE_FOLD  = 3'd2;
    localparam logic [2:0] MODE_WHOLE_CASE  = 3'd3;
    localparam logic [2:0] MODE_LIST        = 3'd4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_CASE_GAP = 8'h20;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] MIN_VALUE_LEN = 16'd4;

    typedef struct packed {
        logic       action;
        logic [3:0] pattern_select;
        logic [5:0] load_position;
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic [2:0] match_mode;
    } in_item_t;

    typedef struct packed {
        logic       matched;
        logic [6:0] consumed_length;
    } out_item_t;

    typedef enum logic [1:0] {
        PH_COMPARE = 2'd0,
        PH_SKIP    = 2'd1,
        PH_SPACE   = 2'd2
    } list_phase_t;

    typedef struct packed {
        logic [6:0]  cp;
        logic [15:0] count;
        logic        mismatch;
        list_phase_t phase;
        logic        found;
    } attempt_t;

    localparam attempt_t ATT_CLEAR = '{
        cp:       7'd0,
        count:    16'd0,
        mismatch: 1'b0,
        phase:    PH_COMPARE,
        found:    1'b0
    };

    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            r = b + CHAR_CASE_GAP;
        end
        return r;
    endfunction

endpackage

@@ design/htm_stream_if.sv @@
// Valid/ready stream channel carrying one payload item per transfer.
interface htm_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ design/htm_token_mem.sv @@
// Token byte store: one write port, one registered read port.
module htm_token_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/htm_match_core.sv @@
// Compare stage: attempt state, token lengths, store addressing and result decision.
module htm_match_core import htm_pkg::*; #(
    parameter int TOKEN_COUNT   = TOKEN_COUNT_DEF,
    parameter int TOKEN_MAX_LEN = TOKEN_MAX_LEN_DEF,
    parameter int ADDR_W        = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  in_item_t          in_item,
    output logic              in_ready,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_waddr,
    output logic [7:0]        mem_wdata,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_raddr,
    input  logic [7:0]        mem_rdata,
    output logic              res_valid,
    output out_item_t         res,
    input  logic              res_ready
);

    localparam int SEL_W = (TOKEN_COUNT > 1) ? $clog2(TOKEN_COUNT) : 1;
    localparam int POS_W = $clog2(TOKEN_MAX_LEN);

    function automatic logic [ADDR_W-1:0] token_addr(input logic [3:0] sel,
                                                     input logic [POS_W-1:0] pos);
        int a;
        a = int'(SEL_W'(sel)) * TOKEN_MAX_LEN + int'(pos);
        return ADDR_W'(a);
    endfunction

    logic [6:0]  len_reg [TOKEN_COUNT];
    attempt_t    att_reg, att_next, att_post;
    logic        s1_valid_reg;
    in_item_t    s1_reg;
    logic        s1_adv;

    // working values of the item in the compare stage
    attempt_t    st;
    logic        s1_sel_ok;
    logic [6:0]  tlen;
    logic [7:0]  msg_byte;
    logic        is_fixed, is_fold, is_prefix, is_list;
    logic        ok;

    // read address for the arriving item
    attempt_t    fwd_st, rd_st;
    logic [POS_W-1:0] rd_pos;
    logic        in_sel_ok;
    logic        load_ok;

    assign in_sel_ok = int'(in_item.pattern_select) < TOKEN_COUNT;
    assign load_ok   = in_fire && (in_item.action == ACT_LOAD) && in_sel_ok
                       && (int'(in_item.load_position) < TOKEN_MAX_LEN);

    assign mem_we    = load_ok;
    assign mem_waddr = token_addr(in_item.pattern_select, POS_W'(in_item.load_position));
    assign mem_wdata = in_item.data_byte;

    assign s1_adv    = s1_valid_reg && (!s1_reg.last_byte || res_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign res_valid = s1_valid_reg && s1_reg.last_byte;

    // Forward the state left by the item in the compare stage to the next read address.
    always_comb
    begin
        fwd_st = s1_valid_reg ? att_post : att_reg;
        rd_st  = in_item.first_byte ? ATT_CLEAR : fwd_st;
        rd_pos = (in_item.match_mode == MODE_LIST) ? POS_W'(rd_st.cp) : POS_W'(rd_st.count);
        mem_re = in_fire && (in_item.action == ACT_MESSAGE);
        mem_raddr = in_sel_ok ? token_addr(in_item.pattern_select, rd_pos) : '0;
    end

    always_comb
    begin
        st        = s1_reg.first_byte ? ATT_CLEAR : att_reg;
        att_post  = st;
        s1_sel_ok = int'(s1_reg.pattern_select) < TOKEN_COUNT;
        tlen      = s1_sel_ok ? len_reg[SEL_W'(s1_reg.pattern_select)] : 7'd0;
        is_fixed  = (s1_reg.match_mode == MODE_PREFIX_FOLD)
                    || (s1_reg.match_mode == MODE_PREFIX_CASE)
                    || (s1_reg.match_mode == MODE_WHOLE_FOLD)
                    || (s1_reg.match_mode == MODE_WHOLE_CASE);
        is_fold   = (s1_reg.match_mode == MODE_PREFIX_FOLD)
                    || (s1_reg.match_mode == MODE_WHOLE_FOLD);
        is_prefix = (s1_reg.match_mode == MODE_PREFIX_FOLD)
                    || (s1_reg.match_mode == MODE_PREFIX_CASE);
        is_list   = s1_reg.match_mode == MODE_LIST;
        msg_byte  = is_fold ? fold_case(s1_reg.data_byte) : s1_reg.data_byte;

        if (is_fixed)
        begin
            if (!s1_sel_ok)
            begin
                att_post.mismatch = 1'b1;
            end
            else if (st.count < {9'd0, tlen} && msg_byte != mem_rdata)
            begin
                att_post.mismatch = 1'b1;
            end
        end
        else if (is_list)
        begin
            if (!s1_sel_ok)
            begin
                att_post.mismatch = 1'b1;
            end
            else if (!st.found && !st.mismatch)
            begin
                unique case (st.phase)
                    PH_COMPARE:
                    begin
                        if (st.cp < tlen)
                        begin
                            if (fold_case(s1_reg.data_byte) != mem_rdata)
                            begin
                                att_post.phase = PH_SKIP;
                            end
                            else
                            begin
                                att_post.cp = st.cp + 7'd1;
                                if ((st.cp + 7'd1) == tlen && s1_reg.last_byte)
                                begin
                                    att_post.found = 1'b1;
                                end
                            end
                        end
                        else if (s1_reg.data_byte == CHAR_COMMA)
                        begin
                            att_post.found = 1'b1;
                        end
                        else
                        begin
                            att_post.phase = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        if (s1_reg.data_byte == CHAR_COMMA)
                        begin
                            att_post.phase = PH_SPACE;
                        end
                    end
                    PH_SPACE:
                    begin
                        if (s1_reg.data_byte == CHAR_SPACE)
                        begin
                            att_post.phase = PH_COMPARE;
                            att_post.cp    = 7'd0;
                        end
                        else
                        begin
                            att_post.mismatch = 1'b1;
                        end
                    end
                    default:
                    begin
                        att_post.mismatch = 1'b1;
                    end
                endcase
            end
        end

        if (st.count != COUNT_MAX)
        begin
            att_post.count = st.count + 16'd1;
        end

        ok = s1_sel_ok && !att_post.mismatch && (att_post.count >= MIN_VALUE_LEN);
        if (is_prefix)
        begin
            ok = ok && (att_post.count >= {9'd0, tlen});
        end
        else
        begin
            ok = ok && (att_post.count == {9'd0, tlen});
        end

        res = '{matched: 1'b0, consumed_length: 7'd0};
        if (is_fixed && ok)
        begin
            res = '{matched: 1'b1, consumed_length: tlen};
        end
        else if (is_list)
        begin
            res.matched = att_post.found && s1_sel_ok;
        end

        att_next = s1_adv ? att_post : att_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg      <= ATT_CLEAR;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < TOKEN_COUNT; i++)
            begin
                len_reg[i] <= 7'd0;
            end
        end
        else
        begin
            att_reg <= att_next;
            if (in_fire && in_item.action == ACT_MESSAGE)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (load_ok && in_item.last_byte)
            begin
                len_reg[SEL_W'(in_item.pattern_select)] <= 7'({1'b0, in_item.load_position}) + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_item.action == ACT_MESSAGE)
        begin
            s1_reg <= in_item;
        end
    end

    a_first_restarts_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_reg.first_byte) |=> (att_reg.count == 16'd1))
        else $error("count did not restart on first byte");

    a_mismatch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_reg.first_byte && att_reg.mismatch) |=> att_reg.mismatch)
        else $error("mismatch cleared inside an attempt");

    a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !s1_reg.first_byte && att_reg.found) |=> att_reg.found)
        else $error("list hit cleared inside an attempt");

endmodule

@@ design/htm_out_stage.sv @@
// Result register between the compare stage and the output channel.
module htm_out_stage import htm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      res_valid,
    input  out_item_t res,
    output logic      res_ready,
    htm_stream_if.source out
);

    logic      valid_reg;
    out_item_t data_reg;

    assign res_ready   = !valid_reg || out.ready;
    assign out.valid   = valid_reg;
    assign out.payload = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res;
        end
    end

endmodule

@@ design/header_token_matcher.sv @@
// Header token matcher: top level.
//
// Channel in carries one item per transfer: a token byte to store (action 0)
// or one byte of a header value (action 1). Token bytes go straight into the
// token store; a load with last_byte set fixes that token's length.
// Channel out carries one result (matched, consumed_length) for each value
// byte that has last_byte set; other items give no result.
// Throughput: one item per cycle, any mix of loads and value bytes, while out
// does not stall. The figure is set by the single read port of the token
// store: each value byte reads one token byte, and the list position left by
// one byte is forwarded into the read address of the next.
// Path to a result: the last byte is registered into the compare stage, its
// result is decided there and registered into the result register, which
// drives out.
// Reset clears token lengths, attempt state and both stages at once; token
// bytes hold nothing until loaded.
// When out stalls with a result held, a further last byte waits in the compare
// stage and in.ready drops; nothing is dropped or repeated.
module header_token_matcher import htm_pkg::*; #(
    parameter int TOKEN_COUNT   = TOKEN_COUNT_DEF,
    parameter int TOKEN_MAX_LEN = TOKEN_MAX_LEN_DEF
) (
    input logic clk,
    input logic rst_n,
    htm_stream_if.sink   in,
    htm_stream_if.source out
);

    localparam int DEPTH  = TOKEN_COUNT * TOKEN_MAX_LEN;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              in_fire;
    logic              core_ready;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;
    logic              res_valid;
    logic              res_ready;
    out_item_t         res;
    in_item_t          in_item;

    assign in_item  = in.payload;
    assign in.ready = core_ready;
    assign in_fire  = in.valid && core_ready;

    htm_token_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    htm_match_core #(
        .TOKEN_COUNT   (TOKEN_COUNT),
        .TOKEN_MAX_LEN (TOKEN_MAX_LEN),
        .ADDR_W        (ADDR_W)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_item   (in_item),
        .in_ready  (core_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    htm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .out       (out)
    );

endmodule
